### hdl/rrts_pkg.sv
package rrts_pkg;

   localparam int MaxThreadsDefault = 16;
   localparam int SlotWidth = 4;
   localparam int TimeWidth = 63;
   localparam int DeadlineWidth = 64;
   localparam int HorizonWidth = 40;
   localparam logic [HorizonWidth-1:0] HorizonReset = 40'd10000000000;
   localparam logic [TimeWidth-1:0] TimeMax = {TimeWidth{1'b1}};

   typedef enum logic [2:0] {
      MODE_CREATE  = 3'd0,
      MODE_EXIT    = 3'd1,
      MODE_BLOCK   = 3'd2,
      MODE_SLEEP   = 3'd3,
      MODE_WAKE    = 3'd4,
      MODE_YIELD   = 3'd5,
      MODE_SCHED   = 3'd6,
      MODE_COLLECT = 3'd7
   } mode_type;

   typedef struct packed {
      logic [2:0]              mode;
      logic [SlotWidth-1:0]    thread_slot;
      logic [DeadlineWidth-1:0] deadline;
      logic [TimeWidth-1:0]    now;
   } req_word_type;

   typedef struct packed {
      logic                 status;
      logic                 found;
      logic [SlotWidth-1:0] chosen_slot;
      logic [TimeWidth-1:0] next_wakeup;
      logic                 timed_out;
   } rsp_word_type;

endpackage

### hdl/rrts_req_if.sv
interface rrts_req_if;
   logic valid;
   logic ready;
   rrts_pkg::req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

### hdl/rrts_rsp_if.sv
interface rrts_rsp_if;
   logic valid;
   logic ready;
   rrts_pkg::rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

### hdl/rrts_csr_if.sv
interface rrts_csr_if;
   logic valid;
   logic ready;
   logic [rrts_pkg::HorizonWidth-1:0] word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

### hdl/round_robin_thread_scheduler.sv
// channel  dir  payload                                       handshake
// req      in   mode, thread_slot, deadline, now              valid/ready
// rsp      out  status, found, chosen_slot, next_wakeup, ...  valid/ready
// csr      in   idle_horizon                                  valid/ready
// one word at a time; simple ops pass through SREAD, SOP and OUT
// schedule visits order-list positions one by one (SCHED, SREAD, SOP: memory read,
// update, write), exit and yield shift positions one by one (SHIFT, SHIFTW)
// after reset a clearing pass runs through every entry of slot memory
// a result waits in the output register; req is taken again once it is taken
module round_robin_thread_scheduler #(
   parameter int MAX_THREADS = rrts_pkg::MaxThreadsDefault
) (
   input logic clock,
   input logic reset,
   rrts_req_if.sink req,
   rrts_rsp_if.source rsp,
   rrts_csr_if.sink csr
);
   import rrts_pkg::*;

   localparam int IdxW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int CntW = $clog2(MAX_THREADS + 1);
   localparam int EntW = 3 + DeadlineWidth;

   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b0000000001,
      ST_IDLE   = 10'b0000000010,
      ST_SREAD  = 10'b0000000100,
      ST_SOP    = 10'b0000001000,
      ST_FIND   = 10'b0000010000,
      ST_FINDW  = 10'b0000100000,
      ST_SHIFT  = 10'b0001000000,
      ST_SHIFTW = 10'b0010000000,
      ST_SCHED  = 10'b0100000000,
      ST_OUT    = 10'b1000000000
   } state_type;

   // slot memory: present, runnable, timeout, deadline
   logic [EntW-1:0] slot_mem [MAX_THREADS];
   logic [EntW-1:0] slot_rd_ff;
   logic [IdxW-1:0] slot_raddr, slot_waddr;
   logic            slot_we;
   logic [EntW-1:0] slot_wdata;

   logic [SlotWidth-1:0] order_mem [MAX_THREADS];
   logic [SlotWidth-1:0] order_rd_ff;
   logic [IdxW-1:0] order_raddr, order_waddr;
   logic            order_we;
   logic [SlotWidth-1:0] order_wdata;

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
      slot_rd_ff <= slot_mem[slot_raddr];
      if (order_we) order_mem[order_waddr] <= order_wdata;
      order_rd_ff <= order_mem[order_raddr];
   end

   state_type state_ff, state_in;
   req_word_type req_ff, req_in;
   rsp_word_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [HorizonWidth-1:0] horizon_ff, horizon_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] pos_ff, pos_in;
   logic [TimeWidth-1:0] best_ff, best_in;
   logic [SlotWidth-1:0] mover_ff, mover_in;
   logic want_append_ff, want_append_in;

   logic ok;
   logic [TimeWidth:0] wsum;
   logic sp, sr, st;
   logic signed [DeadlineWidth-1:0] sd;
   logic [IdxW-1:0] req_idx;

   assign ok = 32'(req_ff.thread_slot) < MAX_THREADS;
   assign req_idx = IdxW'(req_ff.thread_slot);
   assign {sp, sr, st, sd} = slot_rd_ff;
   assign wsum = {1'b0, req.word.now} + (TimeWidth+1)'(horizon_ff);

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.word = rsp_ff;

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      horizon_in = horizon_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      best_in = best_ff;
      mover_in = mover_ff;
      want_append_in = want_append_ff;
      slot_raddr = req_idx;
      slot_waddr = req_idx;
      slot_we = 1'b0;
      slot_wdata = slot_rd_ff;
      order_raddr = pos_ff[IdxW-1:0];
      order_waddr = pos_ff[IdxW-1:0];
      order_we = 1'b0;
      order_wdata = mover_ff;
      if (csr.valid) horizon_in = csr.word;
      if (rsp.valid && rsp.ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            slot_we = 1'b1;
            slot_waddr = pos_ff[IdxW-1:0];
            slot_wdata = {3'b000, {DeadlineWidth{1'b1}}};
            pos_in = pos_ff + 1'b1;
            if (32'(pos_ff) == MAX_THREADS - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               req_in = req.word;
               rsp_in = '0;
               pos_in = '0;
               best_in = wsum[TimeWidth] ? TimeMax : wsum[TimeWidth-1:0];
               want_append_in = 1'b0;
               if (req.word.mode == MODE_SCHED) begin
                  state_in = (count_ff == '0) ? ST_OUT : ST_SCHED;
                  order_raddr = '0;
               end else begin
                  state_in = ST_SREAD;
                  slot_raddr = IdxW'(req.word.thread_slot);
               end
            end
         end
         ST_SREAD: state_in = ST_SOP;
         ST_SOP: begin
            state_in = ST_OUT;
            if (!ok) rsp_in.status = 1'b1;
            else if (req_ff.mode == MODE_CREATE) begin
               if (sp || 32'(count_ff) >= MAX_THREADS) rsp_in.status = 1'b1;
               else begin
                  slot_we = 1'b1;
                  slot_wdata = {3'b110, {DeadlineWidth{1'b1}}};
                  order_we = 1'b1;
                  order_waddr = count_ff[IdxW-1:0];
                  order_wdata = req_ff.thread_slot;
                  count_in = count_ff + 1'b1;
               end
            end else if (!sp) rsp_in.status = 1'b1;
            else begin
               case (req_ff.mode)
                  MODE_EXIT: begin
                     slot_we = 1'b1;
                     slot_wdata = {3'b000, {DeadlineWidth{1'b1}}};
                     mover_in = req_ff.thread_slot;
                     want_append_in = 1'b0;
                     state_in = ST_FIND;
                     order_raddr = '0;
                  end
                  MODE_BLOCK: begin
                     slot_we = 1'b1;
                     slot_wdata = {1'b1, 1'b0, st, req_ff.deadline};
                  end
                  MODE_SLEEP: begin
                     slot_we = 1'b1;
                     slot_wdata = {3'b100, req_ff.deadline};
                  end
                  MODE_WAKE: begin
                     slot_we = 1'b1;
                     slot_wdata = {1'b1, 1'b1, st, {DeadlineWidth{1'b1}}};
                  end
                  MODE_YIELD: begin
                     mover_in = req_ff.thread_slot;
                     want_append_in = 1'b1;
                     state_in = ST_FIND;
                     order_raddr = '0;
                  end
                  MODE_COLLECT: begin
                     rsp_in.timed_out = st;
                     slot_we = 1'b1;
                     slot_wdata = {sp, sr, 1'b0, sd};
                  end
                  default: ;
               endcase
            end
         end
         ST_FIND: state_in = ST_FINDW;
         ST_FINDW: begin
            // order_rd_ff holds entry at pos_ff
            if (order_rd_ff == mover_ff) begin
               pos_in = pos_ff + 1'b1;
               order_raddr = IdxW'(pos_ff + 1'b1);
               state_in = ST_SHIFT;
            end else if (pos_ff + 1'b1 >= count_ff) begin
               state_in = ST_OUT;
            end else begin
               pos_in = pos_ff + 1'b1;
               order_raddr = IdxW'(pos_ff + 1'b1);
               state_in = ST_FIND;
            end
         end
         ST_SHIFT: state_in = ST_SHIFTW;
         ST_SHIFTW: begin
            // pos_ff is the source position, shift down by one
            if (pos_ff >= count_ff) begin
               if (want_append_ff) begin
                  order_we = 1'b1;
                  order_waddr = IdxW'(count_ff - 1'b1);
                  order_wdata = mover_ff;
               end else count_in = count_ff - 1'b1;
               state_in = ST_OUT;
            end else begin
               order_we = 1'b1;
               order_waddr = IdxW'(pos_ff - 1'b1);
               order_wdata = order_rd_ff;
               pos_in = pos_ff + 1'b1;
               order_raddr = IdxW'(pos_ff + 1'b1);
               state_in = ST_SHIFT;
            end
         end
         ST_SCHED: begin
            // order entry ready next cycle; read slot then
            state_in = ST_SREAD;
            req_in.mode = MODE_SCHED;
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
            if (req_ff.mode == MODE_SCHED && !rsp_ff.found)
               rsp_in.next_wakeup = best_ff;
         end
         default: state_in = ST_IDLE;
      endcase
      // schedule walk uses its own sub-sequence on top of SREAD/SOP
      if (req_ff.mode == MODE_SCHED && state_ff == ST_SREAD && !(state_ff == ST_IDLE)) begin
         slot_raddr = IdxW'(order_rd_ff);
         mover_in = order_rd_ff;
         state_in = ST_SOP;
      end
      if (req_ff.mode == MODE_SCHED && state_ff == ST_SOP) begin
         slot_waddr = IdxW'(mover_ff);
         state_in = ST_OUT;
         rsp_in.status = 1'b0;
         rsp_in.timed_out = 1'b0;
         order_we = 1'b0;
         count_in = count_ff;
         slot_we = 1'b0;
         if (!sr && !sd[DeadlineWidth-1]) begin
            if (sd[TimeWidth-1:0] <= req_ff.now) begin
               slot_we = 1'b1;
               slot_wdata = {sp, 1'b1, 1'b1, {DeadlineWidth{1'b1}}};
            end else if (sd[TimeWidth-1:0] < best_ff) best_in = sd[TimeWidth-1:0];
         end
         if (sr || (!sd[DeadlineWidth-1] && sd[TimeWidth-1:0] <= req_ff.now)) begin
            rsp_in.found = 1'b1;
            rsp_in.chosen_slot = mover_ff;
            rsp_in.next_wakeup = '0;
            want_append_in = 1'b1;
            pos_in = pos_ff + 1'b1;
            order_raddr = IdxW'(pos_ff + 1'b1);
            req_in.mode = MODE_YIELD;
            state_in = ST_SHIFT;
         end else if (pos_ff + 1'b1 < count_ff) begin
            pos_in = pos_ff + 1'b1;
            order_raddr = IdxW'(pos_ff + 1'b1);
            state_in = ST_SCHED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         horizon_ff <= HorizonReset;
         count_ff <= '0;
         pos_ff <= '0;
         want_append_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         horizon_ff <= horizon_in;
         count_ff <= count_in;
         pos_ff <= pos_in;
         want_append_ff <= want_append_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      best_ff <= best_in;
      mover_ff <= mover_in;
   end

endmodule

### hdl/rrts_checker.sv
module rrts_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rrts_pkg::rsp_word_type rsp_word
);
   import rrts_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result dropped while stalled");
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken with result pending");
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.found |-> rsp_word.next_wakeup == '0)
      else $error("wakeup with found");
   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result too early");
endmodule

bind round_robin_thread_scheduler rrts_checker u_rrts_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_word(rsp.word)
);

### bench/round_robin_thread_scheduler_tb.sv
module round_robin_thread_scheduler_tb;
   import rrts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumSlots = MaxThreadsDefault;
   localparam int RandomWords = 700;

   class thread_table_sb;
      logic [HorizonWidth-1:0] horizon;
      bit present [NumSlots];
      bit runnable [NumSlots];
      bit timeout [NumSlots];
      logic signed [DeadlineWidth-1:0] wake_at [NumSlots];
      int order [$];
      rsp_word_type pending [$];
      int errors;

      function new();
         horizon = HorizonReset;
         for (int i = 0; i < NumSlots; i++) begin
            present[i] = 0;
            runnable[i] = 0;
            timeout[i] = 0;
            wake_at[i] = -1;
         end
         errors = 0;
      endfunction

      function void move_to_tail(int s);
         for (int i = 0; i < order.size(); i++) begin
            if (order[i] == s) begin
               order.delete(i);
               break;
            end
         end
         order.push_back(s);
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type r;
         int s;
         logic [TimeWidth:0] sum;
         logic [TimeWidth-1:0] best;
         logic signed [DeadlineWidth-1:0] d;
         r = '0;
         s = w.thread_slot;
         if (mode_type'(w.mode) == MODE_SCHED) begin
            sum = {1'b0, w.now} + (TimeWidth+1)'(horizon);
            best = sum[TimeWidth] ? TimeMax : sum[TimeWidth-1:0];
            for (int i = 0; i < order.size(); i++) begin
               int t;
               t = order[i];
               d = wake_at[t];
               if (!runnable[t] && d >= 0) begin
                  if (d[TimeWidth-1:0] <= w.now) begin
                     timeout[t] = 1;
                     wake_at[t] = -1;
                     runnable[t] = 1;
                  end else if (d[TimeWidth-1:0] < best) begin
                     best = d[TimeWidth-1:0];
                  end
               end
               if (runnable[t]) begin
                  r.found = 1;
                  r.chosen_slot = SlotWidth'(t);
                  move_to_tail(t);
                  break;
               end
            end
            if (!r.found) r.next_wakeup = best;
         end else if (mode_type'(w.mode) == MODE_CREATE) begin
            if (present[s]) r.status = 1;
            else begin
               present[s] = 1;
               runnable[s] = 1;
               timeout[s] = 0;
               wake_at[s] = -1;
               order.push_back(s);
            end
         end else if (!present[s]) begin
            r.status = 1;
         end else begin
            case (mode_type'(w.mode))
               MODE_EXIT: begin
                  move_to_tail(s);
                  void'(order.pop_back());
                  present[s] = 0;
                  runnable[s] = 0;
                  timeout[s] = 0;
                  wake_at[s] = -1;
               end
               MODE_BLOCK, MODE_SLEEP: begin
                  wake_at[s] = w.deadline;
                  runnable[s] = 0;
                  if (mode_type'(w.mode) == MODE_SLEEP) timeout[s] = 0;
               end
               MODE_WAKE: begin
                  wake_at[s] = -1;
                  runnable[s] = 1;
               end
               MODE_YIELD: move_to_tail(s);
               default: begin
                  r.timed_out = timeout[s];
                  timeout[s] = 0;
               end
            endcase
         end
         pending.push_back(r);
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type exp;
         if (pending.size() == 0) begin
            $error("result with nothing expected: %p", got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            errors++;
         end
         if (got.found !== exp.found) begin
            $error("found: expected %0d, got %0d", exp.found, got.found);
            errors++;
         end
         if (got.chosen_slot !== exp.chosen_slot) begin
            $error("chosen_slot: expected %0d, got %0d", exp.chosen_slot,
               got.chosen_slot);
            errors++;
         end
         if (got.next_wakeup !== exp.next_wakeup) begin
            $error("next_wakeup: expected %0d, got %0d", exp.next_wakeup,
               got.next_wakeup);
            errors++;
         end
         if (got.timed_out !== exp.timed_out) begin
            $error("timed_out: expected %0d, got %0d", exp.timed_out,
               got.timed_out);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   rrts_req_if req ();
   rrts_rsp_if rsp ();
   rrts_csr_if csr ();

   round_robin_thread_scheduler DUT (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   thread_table_sb board;
   bit hold_rsp;
   logic [TimeWidth-1:0] sim_now;

   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #50ms;
      $display("round_robin_thread_scheduler_tb: errors");
      $finish;
   end

   // receiver stall pattern plus forced hold-off
   always @(negedge clock) begin
      if (reset || hold_rsp) rsp.ready <= 0;
      else if ($urandom_range(0, 3) == 0) rsp.ready <= ($urandom_range(0, 1) == 1);
      else rsp.ready <= ($urandom_range(0, 5) != 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) board.check_result(rsp.word);
   end

   task automatic send_word(req_word_type w);
      @(negedge clock);
      req.valid <= 1;
      req.word <= w;
      do @(posedge clock); while (!req.ready);
      board.note_request(w);
      @(negedge clock);
      req.valid <= 0;
   endtask

   task automatic write_horizon(logic [HorizonWidth-1:0] h);
      while (board.pending.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      csr.valid <= 1;
      csr.word <= h;
      do @(posedge clock); while (!csr.ready);
      board.horizon = h;
      @(negedge clock);
      csr.valid <= 0;
   endtask

   function automatic req_word_type make_word(mode_type m, int s,
         logic [DeadlineWidth-1:0] d, logic [TimeWidth-1:0] t);
      req_word_type w;
      w.mode = m;
      w.thread_slot = SlotWidth'(s);
      w.deadline = d;
      w.now = t;
      return w;
   endfunction

   function automatic logic [DeadlineWidth-1:0] random_deadline();
      logic [DeadlineWidth-1:0] d;
      case ($urandom_range(0, 4))
         0: d = -1;
         1: d = {$urandom(), $urandom()};
         2: d = DeadlineWidth'({1'b0, $urandom(), $urandom()} >> $urandom_range(0, 62));
         default: d = sim_now + $urandom_range(0, 400) - 150;
      endcase
      return d;
   endfunction

   task automatic random_word();
      mode_type m;
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) m = MODE_CREATE;
      else if (r < 18) m = MODE_EXIT;
      else if (r < 28) m = MODE_BLOCK;
      else if (r < 38) m = MODE_SLEEP;
      else if (r < 46) m = MODE_WAKE;
      else if (r < 54) m = MODE_YIELD;
      else if (r < 90) m = MODE_SCHED;
      else m = MODE_COLLECT;
      sim_now = sim_now + $urandom_range(0, 60);
      if ($urandom_range(0, 30) == 0) sim_now = TimeWidth'({$urandom(), $urandom()});
      send_word(make_word(m, $urandom_range(0, 15), random_deadline(),
         ($urandom_range(0, 40) == 0) ? TimeWidth'({$urandom(), $urandom()}) : sim_now));
   endtask

   initial begin
      int left;
      board = new();
      hold_rsp = 0;
      sim_now = 1000;
      reset = 1;
      req.valid = 0;
      req.word = '0;
      csr.valid = 0;
      csr.word = '0;
      rsp.ready = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed
      send_word(make_word(MODE_SCHED, 0, 0, 0));
      send_word(make_word(MODE_EXIT, 3, 0, 0));
      send_word(make_word(MODE_CREATE, 0, 0, 0));
      send_word(make_word(MODE_CREATE, 15, 0, 0));
      send_word(make_word(MODE_CREATE, 15, 0, 0));
      send_word(make_word(MODE_CREATE, 7, 0, 0));
      send_word(make_word(MODE_BLOCK, 0, 64'd500, 0));
      send_word(make_word(MODE_SLEEP, 15, -1, 0));
      send_word(make_word(MODE_SLEEP, 7, 64'h7fff_ffff_ffff_ffff, 0));
      send_word(make_word(MODE_SCHED, 0, 0, 63'd100));
      send_word(make_word(MODE_SCHED, 0, 0, TimeMax));
      send_word(make_word(MODE_COLLECT, 0, 0, 0));
      send_word(make_word(MODE_COLLECT, 7, 0, 0));
      send_word(make_word(MODE_WAKE, 15, 0, 0));
      send_word(make_word(MODE_YIELD, 15, 0, 0));
      send_word(make_word(MODE_SCHED, 0, 0, 0));
      send_word(make_word(MODE_BLOCK, 15, 64'h8000_0000_0000_0000, 0));
      send_word(make_word(MODE_EXIT, 15, 0, 0));
      send_word(make_word(MODE_COLLECT, 15, 0, 0));
      send_word(make_word(MODE_SCHED, 0, 0, 63'd10));

      write_horizon('0);
      repeat (150) random_word();
      write_horizon({HorizonWidth{1'b1}});
      repeat (150) random_word();
      write_horizon(40'd300);

      // long receiver hold-off while requests keep coming
      fork
         begin
            hold_rsp = 1;
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end
         repeat (40) random_word();
      join

      // pause until drained
      while (board.pending.size() != 0) @(negedge clock);
      left = 360;
      while (left > 0) begin
         int burst;
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            if (left > 0) begin
               random_word();
               left--;
            end
         end
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 30)) @(negedge clock);
      end
      write_horizon(40'd10000000000);
      repeat (20) random_word();

      while (board.pending.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("round_robin_thread_scheduler_tb: clean");
      else
         $display("round_robin_thread_scheduler_tb: errors");
      $finish;
   end

endmodule

### filelist.f
hdl/rrts_pkg.sv
hdl/rrts_req_if.sv
hdl/rrts_rsp_if.sv
hdl/rrts_csr_if.sv
hdl/round_robin_thread_scheduler.sv
hdl/rrts_checker.sv
bench/round_robin_thread_scheduler_tb.sv
